>>> rtl/ttok_pkg.sv
// ----------------------------------------------------------------------------
// ttok_pkg
// Shared types and constants of the text tokenizer: token kinds, register
// indexes, character codes and configuration reset values.
// ----------------------------------------------------------------------------
package ttok_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int SLOTS        = 6;
    localparam int SLOT_W       = 3;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 4;

    typedef enum logic [2:0] {
        TK_WORD   = 3'd0,
        TK_SEP    = 3'd1,
        TK_OPEN   = 3'd2,
        TK_BODY   = 3'd3,
        TK_CLOSE  = 3'd4,
        TK_QUOTED = 3'd5,
        TK_END    = 3'd6
    } token_kind_t;

    typedef enum logic [1:0] {
        REG_KEEP    = 2'd0,
        REG_MASK_LO = 2'd1,
        REG_MASK_MD = 2'd2,
        REG_MASK_HI = 2'd3
    } reg_index_t;

    localparam logic [DATA_W-1:0] MASK_LO_RST = 32'hFC00FF7A;
    localparam logic [DATA_W-1:0] MASK_MD_RST = 32'h78000001;
    localparam logic [DATA_W-1:0] MASK_HI_RST = 32'h68000001;

    localparam logic [7:0] CHR_TAB    = 8'd9;
    localparam logic [7:0] CHR_LF     = 8'd10;
    localparam logic [7:0] CHR_CR     = 8'd13;
    localparam logic [7:0] CHR_SPACE  = 8'd32;
    localparam logic [7:0] CHR_DQUOTE = 8'd34;
    localparam logic [7:0] CHR_SQUOTE = 8'd39;
    localparam logic [7:0] CHR_SLASH  = 8'd47;

    typedef struct packed {
        logic              keep;
        logic [DATA_W-1:0] mask_lo;
        logic [DATA_W-1:0] mask_md;
        logic [DATA_W-1:0] mask_hi;
    } cfg_t;

endpackage

>>> rtl/ttok_cfg.sv
// ----------------------------------------------------------------------------
// ttok_cfg
// APB register file: keep-separators flag and the three separator masks.
// ----------------------------------------------------------------------------
module ttok_cfg
    import ttok_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.keep    <= 1'b0;
            cfg_reg.mask_lo <= MASK_LO_RST;
            cfg_reg.mask_md <= MASK_MD_RST;
            cfg_reg.mask_hi <= MASK_HI_RST;
        end else if (wr_en) begin
            case (idx)
                REG_KEEP:    cfg_reg.keep    <= pwdata[0];
                REG_MASK_LO: cfg_reg.mask_lo <= pwdata;
                REG_MASK_MD: cfg_reg.mask_md <= pwdata;
                REG_MASK_HI: cfg_reg.mask_hi <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_KEEP:    prdata = {{(DATA_W-1){1'b0}}, cfg_reg.keep};
            REG_MASK_LO: prdata = cfg_reg.mask_lo;
            REG_MASK_MD: prdata = cfg_reg.mask_md;
            REG_MASK_HI: prdata = cfg_reg.mask_hi;
            default:     prdata = '0;
        endcase
    end

endmodule

>>> rtl/ttok_scan.sv
// ----------------------------------------------------------------------------
// ttok_scan
// Scanner state and the per-byte token logic. For each byte it produces a
// fixed set of candidate token slots in emission order, each with a valid bit.
// ----------------------------------------------------------------------------
module ttok_scan
    import ttok_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                accept,
    input  logic [7:0]          text_byte,
    input  logic                final_byte,
    output logic [SLOTS-1:0]    slot_valid,
    output token_kind_t         slot_kind  [SLOTS],
    output logic [POS_BITS-1:0] slot_start [SLOTS],
    output logic [POS_BITS-1:0] slot_len   [SLOTS],
    output logic [POS_BITS-1:0] slot_line  [SLOTS],
    output logic [POS_BITS-1:0] slot_col   [SLOTS]
);

    typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_QUOTE} mode_t;
    typedef enum logic [1:0] {NL_NONE, NL_LF, NL_CR} nl_t;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
    localparam logic [POS_BITS-1:0] POS_TWO = POS_BITS'(2);

    logic [POS_BITS-1:0] offset_reg, offset_next;
    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic [POS_BITS-1:0] tstart_reg, tstart_next;
    logic [POS_BITS-1:0] tline_reg, tline_next;
    logic [POS_BITS-1:0] tcol_reg, tcol_next;
    mode_t               mode_reg, mode_next;
    nl_t                 nl_reg, nl_next;
    logic                dquote_reg, dquote_next;
    logic                slash_reg, slash_next;

    logic        is_ws, is_sep, is_quote, mask_bit;
    logic [7:0]  close_char;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + POS_ONE;
    endfunction

    function automatic logic [POS_BITS-1:0] span(input logic [POS_BITS-1:0] from,
                                                 input logic [POS_BITS-1:0] upto);
        return (upto >= from) ? upto - from : '0;
    endfunction

    always_comb begin
        case (text_byte[6:5])
            2'd1:    mask_bit = cfg.mask_lo[text_byte[4:0]];
            2'd2:    mask_bit = cfg.mask_md[text_byte[4:0]];
            2'd3:    mask_bit = cfg.mask_hi[text_byte[4:0]];
            default: mask_bit = 1'b0;
        endcase
    end

    assign is_ws      = (text_byte == CHR_SPACE) ||
                        ((text_byte >= CHR_TAB) && (text_byte <= CHR_CR));
    assign is_sep     = !text_byte[7] && mask_bit;
    assign is_quote   = (text_byte == CHR_DQUOTE) || (text_byte == CHR_SQUOTE);
    assign close_char = dquote_reg ? CHR_DQUOTE : CHR_SQUOTE;

    // Slot order: held slash release, main token 1, main token 2,
    // newly held slash at end of text, open token flush, end marker.
    always_comb begin
        slot_valid  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_kind[i]  = TK_WORD;
            slot_start[i] = '0;
            slot_len[i]   = '0;
            slot_line[i]  = '0;
            slot_col[i]   = '0;
        end
        offset_next = sat_inc(offset_reg);
        line_next   = line_reg;
        col_next    = col_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        mode_next   = mode_reg;
        nl_next     = NL_NONE;
        dquote_next = dquote_reg;
        slash_next  = 1'b0;

        if (slash_reg) begin
            slot_valid[0] = 1'b1;
            slot_kind[0]  = TK_SEP;
            slot_start[0] = tstart_reg;
            slot_len[0]   = (text_byte == CHR_SLASH) ? POS_TWO : POS_ONE;
            slot_line[0]  = tline_reg;
            slot_col[0]   = tcol_reg;
        end

        if (!(slash_reg && text_byte == CHR_SLASH)) begin
            if (mode_reg == MODE_QUOTE) begin
                if (text_byte == close_char) begin
                    slot_valid[1] = 1'b1;
                    if (cfg.keep) begin
                        slot_kind[1]  = TK_BODY;
                        slot_start[1] = sat_inc(tstart_reg);
                        slot_len[1]   = span(sat_inc(tstart_reg), offset_reg);
                        slot_line[1]  = tline_reg;
                        slot_col[1]   = sat_inc(tcol_reg);
                        slot_valid[2] = 1'b1;
                        slot_kind[2]  = TK_CLOSE;
                        slot_start[2] = offset_reg;
                        slot_len[2]   = POS_ONE;
                        slot_line[2]  = line_reg;
                        slot_col[2]   = col_reg;
                    end else begin
                        slot_kind[1]  = TK_QUOTED;
                        slot_start[1] = tstart_reg;
                        slot_len[1]   = sat_inc(span(tstart_reg, offset_reg));
                        slot_line[1]  = tline_reg;
                        slot_col[1]   = tcol_reg;
                    end
                    mode_next = MODE_IDLE;
                end
            end else if (is_ws || is_sep || is_quote) begin
                if (mode_reg == MODE_WORD) begin
                    slot_valid[1] = 1'b1;
                    slot_kind[1]  = TK_WORD;
                    slot_start[1] = tstart_reg;
                    slot_len[1]   = span(tstart_reg, offset_reg);
                    slot_line[1]  = tline_reg;
                    slot_col[1]   = tcol_reg;
                end
                mode_next = MODE_IDLE;
                if (!is_ws) begin
                    tstart_next   = offset_reg;
                    tline_next    = line_reg;
                    tcol_next     = col_reg;
                    slot_start[2] = offset_reg;
                    slot_len[2]   = POS_ONE;
                    slot_line[2]  = line_reg;
                    slot_col[2]   = col_reg;
                    if (is_sep) begin
                        // With keep set, a separator slash waits to see whether a second one follows.
                        if (cfg.keep && text_byte == CHR_SLASH) begin
                            slash_next = 1'b1;
                        end else if (cfg.keep) begin
                            slot_valid[2] = 1'b1;
                            slot_kind[2]  = TK_SEP;
                        end
                    end else begin
                        mode_next     = MODE_QUOTE;
                        dquote_next   = (text_byte == CHR_DQUOTE);
                        slot_valid[2] = cfg.keep;
                        slot_kind[2]  = TK_OPEN;
                    end
                end
            end else if (mode_reg != MODE_WORD) begin
                mode_next   = MODE_WORD;
                tstart_next = offset_reg;
                tline_next  = line_reg;
                tcol_next   = col_reg;
            end
        end

        // A CR after LF, or an LF after CR, closes the same line ending.
        if ((nl_reg == NL_LF && text_byte == CHR_CR) ||
            (nl_reg == NL_CR && text_byte == CHR_LF)) begin
            nl_next = NL_NONE;
        end else if (text_byte == CHR_LF || text_byte == CHR_CR) begin
            line_next = sat_inc(line_reg);
            col_next  = POS_ONE;
            nl_next   = (text_byte == CHR_LF) ? NL_LF : NL_CR;
        end else begin
            col_next = sat_inc(col_reg);
        end

        if (final_byte) begin
            slot_valid[3] = slash_next;
            slot_kind[3]  = TK_SEP;
            slot_start[3] = tstart_next;
            slot_len[3]   = POS_ONE;
            slot_line[3]  = tline_next;
            slot_col[3]   = tcol_next;

            slot_start[4] = tstart_next;
            slot_len[4]   = sat_inc(span(tstart_next, offset_reg));
            slot_line[4]  = tline_next;
            slot_col[4]   = tcol_next;
            if (mode_next == MODE_WORD) begin
                slot_valid[4] = 1'b1;
                slot_kind[4]  = TK_WORD;
            end else if (mode_next == MODE_QUOTE) begin
                slot_valid[4] = 1'b1;
                if (cfg.keep) begin
                    // The open body runs through the final byte.
                    slot_kind[4]  = TK_BODY;
                    slot_start[4] = sat_inc(tstart_next);
                    slot_len[4]   = span(tstart_next, offset_reg);
                    slot_col[4]   = sat_inc(tcol_next);
                end else begin
                    slot_kind[4]  = TK_QUOTED;
                end
            end

            slot_valid[5] = 1'b1;
            slot_kind[5]  = TK_END;
            slot_start[5] = offset_next;
            slot_len[5]   = '0;
            slot_line[5]  = line_next;
            slot_col[5]   = col_next;

            offset_next = '0;
            line_next   = POS_ONE;
            col_next    = POS_ONE;
            tstart_next = '0;
            tline_next  = POS_ONE;
            tcol_next   = POS_ONE;
            mode_next   = MODE_IDLE;
            nl_next     = NL_NONE;
            dquote_next = 1'b0;
            slash_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            line_reg   <= POS_ONE;
            col_reg    <= POS_ONE;
            tstart_reg <= '0;
            tline_reg  <= POS_ONE;
            tcol_reg   <= POS_ONE;
            mode_reg   <= MODE_IDLE;
            nl_reg     <= NL_NONE;
            dquote_reg <= 1'b0;
            slash_reg  <= 1'b0;
        end else if (accept) begin
            offset_reg <= offset_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            mode_reg   <= mode_next;
            nl_reg     <= nl_next;
            dquote_reg <= dquote_next;
            slash_reg  <= slash_next;
        end
    end

endmodule

>>> rtl/ttok_out.sv
// ----------------------------------------------------------------------------
// ttok_out
// Token group register. Holds the tokens of one byte and hands them out one
// per transaction, lowest slot first.
// ----------------------------------------------------------------------------
module ttok_out
    import ttok_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [SLOTS-1:0]    in_valid,
    input  token_kind_t         in_kind  [SLOTS],
    input  logic [POS_BITS-1:0] in_start [SLOTS],
    input  logic [POS_BITS-1:0] in_len   [SLOTS],
    input  logic [POS_BITS-1:0] in_line  [SLOTS],
    input  logic [POS_BITS-1:0] in_col   [SLOTS],
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_token_kind,
    output logic [POS_BITS-1:0] m_start_offset,
    output logic [POS_BITS-1:0] m_token_length,
    output logic [POS_BITS-1:0] m_line_number,
    output logic [POS_BITS-1:0] m_column_number,
    output logic                m_last_token
);

    logic [SLOTS-1:0]    valid_reg, valid_next;
    token_kind_t         kind_reg  [SLOTS];
    logic [POS_BITS-1:0] start_reg [SLOTS];
    logic [POS_BITS-1:0] len_reg   [SLOTS];
    logic [POS_BITS-1:0] line_reg  [SLOTS];
    logic [POS_BITS-1:0] col_reg   [SLOTS];
    logic [SLOT_W-1:0]   sel;
    logic [SLOTS-1:0]    sel_oh;
    logic                last_one;

    assign sel_oh   = valid_reg & (~valid_reg + SLOTS'(1));
    assign last_one = (valid_reg & (valid_reg - SLOTS'(1))) == '0;
    assign m_valid  = |valid_reg;
    assign free     = !m_valid || (m_ready && last_one);

    always_comb begin
        sel = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign m_token_kind    = kind_reg[sel];
    assign m_start_offset  = start_reg[sel];
    assign m_token_length  = len_reg[sel];
    assign m_line_number   = line_reg[sel];
    assign m_column_number = col_reg[sel];
    assign m_last_token    = (kind_reg[sel] == TK_END);

    always_comb begin
        valid_next = valid_reg;
        if (m_valid && m_ready) begin
            valid_next = valid_reg & ~sel_oh;
        end
        if (load) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= in_kind;
            start_reg <= in_start;
            len_reg   <= in_len;
            line_reg  <= in_line;
            col_reg   <= in_col;
        end
    end

endmodule

>>> rtl/text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// text_tokenizer_unit
// Streaming lexical tokenizer: one text byte in, zero to four tokens out.
// ----------------------------------------------------------------------------
// Input channel s_*: one text byte per transaction, with s_final_byte set on
// the last byte of a text. Output channel m_*: one token per transaction with
// kind, start offset, length, line and column; m_last_token marks the end
// marker that closes each text.
// A byte is scanned in the cycle it is accepted and its tokens appear in the
// group register on the next cycle. The group register hands out one token
// per cycle while m_ready is high; a byte that makes zero or one token then
// leaves room for the next byte every cycle, and a byte that makes more
// tokens holds the input until the last of them is being taken.
// When the receiver stalls, the pending tokens stay put and s_ready drops once
// the group register cannot be emptied in the current cycle. Reset clears the
// scan position to offset 0, line 1, column 1, empties the group register and
// loads the configuration defaults. The user writes configuration over the APB
// port only while no byte is in flight; the block itself does not check this.
// ----------------------------------------------------------------------------
module text_tokenizer_unit
    import ttok_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_text_byte,
    input  logic                s_final_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_token_kind,
    output logic [POS_BITS-1:0] m_start_offset,
    output logic [POS_BITS-1:0] m_token_length,
    output logic [POS_BITS-1:0] m_line_number,
    output logic [POS_BITS-1:0] m_column_number,
    output logic                m_last_token
);

    cfg_t                cfg;
    logic                accept;
    logic [SLOTS-1:0]    slot_valid;
    token_kind_t         slot_kind  [SLOTS];
    logic [POS_BITS-1:0] slot_start [SLOTS];
    logic [POS_BITS-1:0] slot_len   [SLOTS];
    logic [POS_BITS-1:0] slot_line  [SLOTS];
    logic [POS_BITS-1:0] slot_col   [SLOTS];

    assign accept = s_valid && s_ready;

    ttok_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ttok_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .accept     (accept),
        .text_byte  (s_text_byte),
        .final_byte (s_final_byte),
        .slot_valid (slot_valid),
        .slot_kind  (slot_kind),
        .slot_start (slot_start),
        .slot_len   (slot_len),
        .slot_line  (slot_line),
        .slot_col   (slot_col)
    );

    ttok_out #(
        .POS_BITS (POS_BITS)
    ) u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (accept),
        .in_valid        (slot_valid),
        .in_kind         (slot_kind),
        .in_start        (slot_start),
        .in_len          (slot_len),
        .in_line         (slot_line),
        .in_col          (slot_col),
        .free            (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_start_offset  (m_start_offset),
        .m_token_length  (m_token_length),
        .m_line_number   (m_line_number),
        .m_column_number (m_column_number),
        .m_last_token    (m_last_token)
    );

endmodule
